@@ design/efrf_pkg.sv @@
// Shared types and constants for the Ethernet frame receive filter.
package efrf_pkg;

  localparam int BufferBytes = 1536;
  localparam int CountW      = 11;
  localparam int LengthW     = 17;
  localparam int MacW        = 48;

  localparam logic [MacW-1:0] OwnMacReset  = 48'hAEF0_285D_6620;
  localparam logic [MacW-1:0] BroadcastMac = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0]     EthTypeIpv4  = 16'h0800;
  localparam logic [15:0]     EthTypeArp   = 16'h0806;
  localparam logic [CountW-1:0] EthHeaderBytes = CountW'(14);
  localparam logic [CountW-1:0] Ipv4LenEnd     = CountW'(18);
  localparam logic [LengthW-1:0] ArpFrameBytes = LengthW'(42);

  // Header byte positions
  localparam logic [CountW-1:0] DestLastPos  = CountW'(5);
  localparam logic [CountW-1:0] TypeHiPos    = CountW'(12);
  localparam logic [CountW-1:0] TypeLoPos    = CountW'(13);
  localparam logic [CountW-1:0] IpLenHiPos   = CountW'(16);
  localparam logic [CountW-1:0] IpLenLoPos   = CountW'(17);

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;
  localparam int QueueCntW  = 3;

  typedef enum logic [1:0] {
    StInProgress   = 2'd0,
    StComplete     = 2'd1,
    StDropInvalid  = 2'd2,
    StDropOverflow = 2'd3
  } status_e;

  typedef struct packed {
    status_e               status;
    logic [CountW-1:0]     received_count;
    logic [LengthW-1:0]    frame_length;
    logic                  frame_type;
  } result_t;

endpackage

@@ design/efrf_if.sv @@
// Valid/ready channels for frame bytes in and chunk results out.
interface efrf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_end;

  modport source (output valid, output data_byte, output chunk_end, input ready);
  modport sink   (input valid, input data_byte, input chunk_end, output ready);
endinterface

interface efrf_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [efrf_pkg::CountW-1:0]  received_count;
  logic [efrf_pkg::LengthW-1:0] frame_length;
  logic                        frame_type;

  modport source (output valid, output status, output received_count,
                  output frame_length, output frame_type, input ready);
  modport sink   (input valid, input status, input received_count,
                  input frame_length, input frame_type, output ready);
endinterface

@@ design/efrf_front.sv @@
// Front end: counts frame bytes, captures header fields, judges at chunk end.
module efrf_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       own_mac_we_i,
  input  logic [efrf_pkg::MacW-1:0]  own_mac_i,
  efrf_in_if.sink                    in_chan,
  input  logic                       push_ready_i,
  output logic                       push_valid_o,
  output efrf_pkg::result_t          push_data_o
);
  import efrf_pkg::*;

  logic [MacW-1:0]   own_mac_q;
  logic [CountW-1:0] count_q, count_d, count_upd;
  logic [MacW-1:0]   dest_q, dest_d, dest_upd;
  logic [15:0]       type_q, type_d, type_upd;
  logic [15:0]       iplen_q, iplen_d, iplen_upd;
  logic              ovf_q, ovf_d, ovf_upd;

  logic    accept;
  logic    full_now;
  logic    hdr_ok;
  logic    valid_frame;
  logic    is_arp;
  logic [LengthW-1:0] length;
  status_e status;

  assign in_chan.ready = push_ready_i;
  assign accept        = in_chan.valid && in_chan.ready;
  assign full_now      = (count_q == CountW'(BufferBytes));

  // Byte count and header capture
  always_comb begin
    count_upd = count_q;
    dest_upd  = dest_q;
    type_upd  = type_q;
    iplen_upd = iplen_q;
    ovf_upd   = ovf_q;
    if (accept) begin
      if (!full_now) begin
        if (count_q <= DestLastPos) begin
          dest_upd = {dest_q[MacW-9:0], in_chan.data_byte};
        end else if (count_q == TypeHiPos || count_q == TypeLoPos) begin
          type_upd = {type_q[7:0], in_chan.data_byte};
        end else if (count_q == IpLenHiPos || count_q == IpLenLoPos) begin
          iplen_upd = {iplen_q[7:0], in_chan.data_byte};
        end
        count_upd = count_q + CountW'(1);
      end else begin
        // drop the byte, remember the overflow
        ovf_upd = 1'b1;
      end
    end
  end

  // Judge the frame as it stands after this byte
  always_comb begin
    hdr_ok      = (count_upd >= EthHeaderBytes) &&
                  (dest_upd == own_mac_q || dest_upd == BroadcastMac);
    valid_frame = 1'b0;
    is_arp      = 1'b0;
    length      = '0;
    if (hdr_ok) begin
      if (type_upd == EthTypeIpv4 && count_upd >= Ipv4LenEnd) begin
        valid_frame = 1'b1;
        length      = {1'b0, iplen_upd} + LengthW'(14);
      end else if (type_upd == EthTypeArp) begin
        valid_frame = 1'b1;
        is_arp      = 1'b1;
        length      = ArpFrameBytes;
      end
    end
    if (!valid_frame) begin
      status = StDropInvalid;
    end else if (ovf_upd) begin
      status = StDropOverflow;
    end else if ({{(LengthW-CountW){1'b0}}, count_upd} >= length) begin
      status = StComplete;
    end else begin
      status = StInProgress;
    end
  end

  assign push_valid_o                = accept && in_chan.chunk_end;
  assign push_data_o.status          = status;
  assign push_data_o.received_count  = count_upd;
  assign push_data_o.frame_length    = length;
  assign push_data_o.frame_type      = is_arp;

  // Restart on any final status
  always_comb begin
    count_d = count_upd;
    dest_d  = dest_upd;
    type_d  = type_upd;
    iplen_d = iplen_upd;
    ovf_d   = ovf_upd;
    if (push_valid_o && status != StInProgress) begin
      count_d = '0;
      dest_d  = '0;
      type_d  = '0;
      iplen_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= OwnMacReset;
      count_q   <= '0;
      dest_q    <= '0;
      type_q    <= '0;
      iplen_q   <= '0;
      ovf_q     <= 1'b0;
    end else begin
      if (own_mac_we_i) begin
        own_mac_q <= own_mac_i;
      end
      count_q <= count_d;
      dest_q  <= dest_d;
      type_q  <= type_d;
      iplen_q <= iplen_d;
      ovf_q   <= ovf_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(BufferBytes))
    else $error("byte count beyond buffer size");

  a_ovf_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> count_q == CountW'(BufferBytes))
    else $error("overflow flag set while buffer not full");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o && status != StInProgress |=> count_q == '0 && !ovf_q)
    else $error("frame state not cleared after final status");

endmodule

@@ design/efrf_back.sv @@
// Back end: result queue that drives the output channel.
module efrf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  efrf_pkg::result_t  push_data_i,
  efrf_out_if.source         out_chan
);
  import efrf_pkg::*;

  result_t              mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 push, pop;
  result_t              head;

  assign push_ready_o = (cnt_q != QueueCntW'(QueueDepth));
  assign push         = push_valid_i && push_ready_o;
  assign pop          = out_chan.valid && out_chan.ready;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QueueCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  assign head                    = mem_q[rd_ptr_q];
  assign out_chan.valid          = (cnt_q != '0);
  assign out_chan.status         = head.status;
  assign out_chan.received_count = head.received_count;
  assign out_chan.frame_length   = head.frame_length;
  assign out_chan.frame_type     = head.frame_type;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntW'(QueueDepth))
    else $error("result queue count beyond depth");

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_i |-> push_ready_o)
    else $error("result offered to a full queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != QueueCntW'(QueueDepth) |->
      QueuePtrW'(wr_ptr_q - rd_ptr_q) == cnt_q[QueuePtrW-1:0])
    else $error("queue pointers disagree with count");

endmodule

@@ design/ethernet_frame_receive_filter.sv @@
// Top level of the Ethernet destination MAC and EtherType receive filter.
//
//  channel    dir  handshake     payload
//  in_chan    in   valid/ready   data_byte[7:0], chunk_end
//  out_chan   out  valid/ready   status[1:0], received_count[10:0],
//                                frame_length[16:0], frame_type
//  own_mac    in   we            own_mac_i[47:0]
//
// One byte per cycle while the result queue has room. A chunk-end byte's result
// is registered into that queue and goes out on out_chan behind older results.
// A 4-entry result queue lets in_chan run while out_chan stalls; in_chan.ready
// drops only when that queue is full. Reset clears the frame state and loads
// the default station MAC.
module ethernet_frame_receive_filter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      own_mac_we_i,
  input  logic [efrf_pkg::MacW-1:0] own_mac_i,
  efrf_in_if.sink                   in_chan,
  efrf_out_if.source                out_chan
);
  import efrf_pkg::*;

  logic    push_valid;
  logic    push_ready;
  result_t push_data;

  efrf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .own_mac_we_i (own_mac_we_i),
    .own_mac_i    (own_mac_i),
    .in_chan      (in_chan),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_data_o  (push_data)
  );

  efrf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .out_chan     (out_chan)
  );

endmodule
